### design/dll_pkg.sv
`default_nettype none
package dll_pkg;

   localparam int POOL_NODES_DEF = 256;
   localparam int ID_BITS_DEF    = 16;

   localparam int KIND_BITS      = 3;
   localparam int ITEM_ID_BITS   = 16;
   localparam int HANDLE_BITS    = 8;
   localparam int STATUS_BITS    = 2;

   localparam logic [KIND_BITS-1:0] KIND_ADD_HEAD  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_ADD_TAIL  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_FIND      = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR_ALL = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_POOL_FULL   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND   = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_IN_USE  = 2'd3;

   typedef struct packed {
      logic link_next;
      logic link_prev;
      logic item;
      logic used;
   } mem_wr_type;

endpackage
`default_nettype wire

### design/dll_if.sv
`default_nettype none
interface dll_req_if;
   import dll_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [KIND_BITS-1:0]    kind;
   logic [ITEM_ID_BITS-1:0] item_id;
   logic [HANDLE_BITS-1:0]  node_handle;

   modport source (output valid, output kind, output item_id, output node_handle,
                   input ready);
   modport sink   (input valid, input kind, input item_id, input node_handle,
                   output ready);
endinterface

interface dll_rsp_if #(
   parameter int LINK_BITS = 9
);
   import dll_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [LINK_BITS-1:0]   result_node;
   logic [STATUS_BITS-1:0] status;
   logic [LINK_BITS-1:0]   list_count;

   modport source (output valid, output result_node, output status, output list_count,
                   input ready);
   modport sink   (input valid, input result_node, input status, input list_count,
                   output ready);
endinterface
`default_nettype wire

### design/dll_node_mem.sv
`default_nettype none
module dll_node_mem #(
   parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
   parameter int ID_BITS    = dll_pkg::ID_BITS_DEF,
   parameter int NODE_BITS  = $clog2(POOL_NODES),
   parameter int LINK_BITS  = $clog2(POOL_NODES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 rd_en,
   input  wire logic [NODE_BITS-1:0] rd_addr,
   output logic      [LINK_BITS-1:0] rd_next,
   output logic      [LINK_BITS-1:0] rd_prev,
   output logic      [ID_BITS-1:0]   rd_id,
   output logic                      rd_used,
   input  wire dll_pkg::mem_wr_type  wr_en,
   input  wire logic [NODE_BITS-1:0] wr_addr,
   input  wire logic [LINK_BITS-1:0] wr_next,
   input  wire logic [LINK_BITS-1:0] wr_prev,
   input  wire logic [ID_BITS-1:0]   wr_id,
   input  wire logic                 wr_used
);
   import dll_pkg::*;

   logic [LINK_BITS-1:0] next_link_ff [POOL_NODES];
   logic [LINK_BITS-1:0] prev_link_ff [POOL_NODES];
   logic [ID_BITS-1:0]   stored_id_ff [POOL_NODES];
   logic                 in_use_ff    [POOL_NODES];

   logic [LINK_BITS-1:0] rd_next_ff;
   logic [LINK_BITS-1:0] rd_prev_ff;
   logic [ID_BITS-1:0]   rd_id_ff;
   logic                 rd_used_ff;

   always_ff @(posedge clock) begin
      if (wr_en.link_next) begin
         next_link_ff[wr_addr] <= wr_next;
      end
      if (wr_en.link_prev) begin
         prev_link_ff[wr_addr] <= wr_prev;
      end
      if (wr_en.item) begin
         stored_id_ff[wr_addr] <= wr_id;
      end
      if (wr_en.used) begin
         in_use_ff[wr_addr] <= wr_used;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_next_ff <= next_link_ff[rd_addr];
         rd_prev_ff <= prev_link_ff[rd_addr];
         rd_id_ff   <= stored_id_ff[rd_addr];
         rd_used_ff <= in_use_ff[rd_addr];
      end
   end

   assign rd_next = rd_next_ff;
   assign rd_prev = rd_prev_ff;
   assign rd_id   = rd_id_ff;
   assign rd_used = rd_used_ff;

endmodule
`default_nettype wire

### design/dll_seq.sv
`default_nettype none
module dll_seq #(
   parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
   parameter int ID_BITS    = dll_pkg::ID_BITS_DEF,
   parameter int NODE_BITS  = $clog2(POOL_NODES),
   parameter int LINK_BITS  = $clog2(POOL_NODES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   dll_req_if.sink                   req_if,
   dll_rsp_if.source                 rsp_if,
   output logic                      rd_en,
   output logic      [NODE_BITS-1:0] rd_addr,
   input  wire logic [LINK_BITS-1:0] rd_next,
   input  wire logic [LINK_BITS-1:0] rd_prev,
   input  wire logic [ID_BITS-1:0]   rd_id,
   input  wire logic                 rd_used,
   output dll_pkg::mem_wr_type       wr_en,
   output logic      [NODE_BITS-1:0] wr_addr,
   output logic      [LINK_BITS-1:0] wr_next,
   output logic      [LINK_BITS-1:0] wr_prev,
   output logic      [ID_BITS-1:0]   wr_id,
   output logic                      wr_used
);
   import dll_pkg::*;

   localparam logic [LINK_BITS-1:0] NONE_LINK = LINK_BITS'(POOL_NODES);
   localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(POOL_NODES - 1);
   localparam int HANDLE_EXT_BITS = HANDLE_BITS + LINK_BITS;

   typedef enum logic [9:0] {
      S_CLEAR     = 10'b00_0000_0001,
      S_IDLE      = 10'b00_0000_0010,
      S_ADD_NODE  = 10'b00_0000_0100,
      S_ADD_LINK  = 10'b00_0000_1000,
      S_REM_CHECK = 10'b00_0001_0000,
      S_REM_LINK  = 10'b00_0010_0000,
      S_REM_FREE  = 10'b00_0100_0000,
      S_FIND      = 10'b00_1000_0000,
      S_FLUSH     = 10'b01_0000_0000,
      S_RESP      = 10'b10_0000_0000
   } state_type;

   state_type               state_ff,  state_in;
   logic [NODE_BITS-1:0]    clr_ff,    clr_in;
   logic [LINK_BITS-1:0]    head_ff,   head_in;
   logic [LINK_BITS-1:0]    tail_ff,   tail_in;
   logic [LINK_BITS-1:0]    free_ff,   free_in;
   logic [LINK_BITS-1:0]    count_ff,  count_in;
   logic [LINK_BITS-1:0]    cur_ff,    cur_in;
   logic [LINK_BITS-1:0]    aux_ff,    aux_in;
   logic [LINK_BITS-1:0]    prv_ff,    prv_in;
   logic [KIND_BITS-1:0]    kind_ff,   kind_in;
   logic [ID_BITS-1:0]      id_ff,     id_in;
   logic [LINK_BITS-1:0]    res_ff,    res_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;

   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [LINK_BITS-1:0]    rsp_node_ff,   rsp_node_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [LINK_BITS-1:0]    rsp_count_ff,  rsp_count_in;

   logic [ID_BITS+ITEM_ID_BITS-1:0] id_ext;
   logic [HANDLE_EXT_BITS-1:0]      handle_ext;
   logic                            handle_ok;
   logic                            head_ok;
   logic                            tail_ok;
   logic                            free_ok;
   logic                            next_ok;
   logic                            prev_ok;
   logic                            aux_ok;

   assign id_ext     = {{ID_BITS{1'b0}}, req_if.item_id};
   assign handle_ext = {{LINK_BITS{1'b0}}, req_if.node_handle};
   assign handle_ok  = handle_ext < HANDLE_EXT_BITS'(POOL_NODES);
   assign head_ok    = head_ff < NONE_LINK;
   assign tail_ok    = tail_ff < NONE_LINK;
   assign free_ok    = free_ff < NONE_LINK;
   assign next_ok    = rd_next < NONE_LINK;
   assign prev_ok    = rd_prev < NONE_LINK;
   assign aux_ok     = aux_ff < NONE_LINK;

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_node = rsp_node_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.list_count  = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      aux_in        = aux_ff;
      prv_in        = prv_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_if.ready;
      rsp_node_in   = rsp_node_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_ff[NODE_BITS-1:0];
      wr_en         = '0;
      wr_addr       = cur_ff[NODE_BITS-1:0];
      wr_next       = NONE_LINK;
      wr_prev       = NONE_LINK;
      wr_id         = id_ff;
      wr_used       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en.link_next = 1'b1;
            wr_en.link_prev = 1'b1;
            wr_en.used      = 1'b1;
            wr_addr         = clr_ff;
            wr_next         = LINK_BITS'(clr_ff) + LINK_BITS'(1);
            clr_in          = clr_ff + NODE_BITS'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_if.valid) begin
               kind_in   = req_if.kind;
               id_in     = id_ext[ID_BITS-1:0];
               res_in    = NONE_LINK;
               status_in = ST_OK;
               state_in  = S_RESP;
               case (req_if.kind)
                  KIND_ADD_HEAD, KIND_ADD_TAIL: begin
                     if (free_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = free_ff[NODE_BITS-1:0];
                        cur_in   = free_ff;
                        state_in = S_ADD_NODE;
                     end else begin
                        status_in = ST_POOL_FULL;
                     end
                  end
                  KIND_REMOVE: begin
                     if (handle_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = handle_ext[NODE_BITS-1:0];
                        cur_in   = handle_ext[LINK_BITS-1:0];
                        state_in = S_REM_CHECK;
                     end else begin
                        status_in = ST_NOT_IN_USE;
                     end
                  end
                  KIND_FIND: begin
                     if (head_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff[NODE_BITS-1:0];
                        cur_in   = head_ff;
                        state_in = S_FIND;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  KIND_CLEAR_ALL: begin
                     if (head_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff[NODE_BITS-1:0];
                        cur_in   = head_ff;
                        state_in = S_FLUSH;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_ADD_NODE: begin
            free_in   = rd_next;
            wr_en     = '{link_next: 1'b1, link_prev: 1'b1, item: 1'b1, used: 1'b1};
            wr_used   = 1'b1;
            count_in  = count_ff + LINK_BITS'(1);
            res_in    = cur_ff;
            if (kind_ff == KIND_ADD_HEAD) begin
               wr_next = head_ff;
               aux_in  = head_ff;
               head_in = cur_ff;
               if (!tail_ok) begin
                  tail_in = cur_ff;
               end
               state_in = head_ok ? S_ADD_LINK : S_RESP;
            end else begin
               wr_prev = tail_ff;
               aux_in  = tail_ff;
               tail_in = cur_ff;
               if (!head_ok) begin
                  head_in = cur_ff;
               end
               state_in = tail_ok ? S_ADD_LINK : S_RESP;
            end
         end
         S_ADD_LINK: begin
            wr_addr = aux_ff[NODE_BITS-1:0];
            if (kind_ff == KIND_ADD_HEAD) begin
               wr_en.link_prev = 1'b1;
               wr_prev         = cur_ff;
            end else begin
               wr_en.link_next = 1'b1;
               wr_next         = cur_ff;
            end
            state_in = S_RESP;
         end
         S_REM_CHECK: begin
            if (!rd_used) begin
               status_in = ST_NOT_IN_USE;
               state_in  = S_RESP;
            end else begin
               prv_in = rd_prev;
               aux_in = rd_next;
               if (prev_ok) begin
                  wr_en.link_next = 1'b1;
                  wr_addr         = rd_prev[NODE_BITS-1:0];
                  wr_next         = rd_next;
               end else begin
                  head_in = rd_next;
               end
               if (!next_ok) begin
                  tail_in = rd_prev;
               end
               state_in = S_REM_LINK;
            end
         end
         S_REM_LINK: begin
            if (aux_ok) begin
               wr_en.link_prev = 1'b1;
               wr_addr         = aux_ff[NODE_BITS-1:0];
               wr_prev         = prv_ff;
            end
            state_in = S_REM_FREE;
         end
         S_REM_FREE: begin
            wr_en.link_next = 1'b1;
            wr_en.link_prev = 1'b1;
            wr_en.used      = 1'b1;
            wr_next         = free_ff;
            free_in         = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - LINK_BITS'(1);
            end
            res_in   = cur_ff;
            state_in = S_RESP;
         end
         S_FIND: begin
            if (rd_id == id_ff) begin
               res_in   = cur_ff;
               state_in = S_RESP;
            end else if (next_ok) begin
               rd_en   = 1'b1;
               rd_addr = rd_next[NODE_BITS-1:0];
               cur_in  = rd_next;
            end else begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end
         end
         S_FLUSH: begin
            wr_en.link_next = 1'b1;
            wr_en.link_prev = 1'b1;
            wr_en.used      = 1'b1;
            wr_next         = free_ff;
            free_in         = cur_ff;
            if (next_ok) begin
               rd_en   = 1'b1;
               rd_addr = rd_next[NODE_BITS-1:0];
               cur_in  = rd_next;
            end else begin
               head_in  = NONE_LINK;
               tail_in  = NONE_LINK;
               count_in = '0;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = res_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= NONE_LINK;
         tail_ff      <= NONE_LINK;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      aux_ff        <= aux_in;
      prv_ff        <= prv_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
`default_nettype wire

### design/doubly_linked_list_manager_core.sv
`default_nettype none
// Channel  Dir  Transfer when        Payload
// req_if   in   valid && ready       kind, item_id, node_handle
// rsp_if   out  valid && ready       result_node, status, list_count
//
// One request at a time. Find and remove all walk the list one node at a time:
// each node costs one read of the node memory, whose read data is registered.
// After reset a clearing pass writes the free chain over every node; req_if.ready
// stays low until it ends.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result is ready and the register is full.
module doubly_linked_list_manager_core #(
   parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
   parameter int ID_BITS    = dll_pkg::ID_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   dll_req_if.sink   req_if,
   dll_rsp_if.source rsp_if
);
   import dll_pkg::*;

   localparam int NODE_BITS = $clog2(POOL_NODES);
   localparam int LINK_BITS = $clog2(POOL_NODES + 1);

   logic                 rd_en;
   logic [NODE_BITS-1:0] rd_addr;
   logic [LINK_BITS-1:0] rd_next;
   logic [LINK_BITS-1:0] rd_prev;
   logic [ID_BITS-1:0]   rd_id;
   logic                 rd_used;
   mem_wr_type           wr_en;
   logic [NODE_BITS-1:0] wr_addr;
   logic [LINK_BITS-1:0] wr_next;
   logic [LINK_BITS-1:0] wr_prev;
   logic [ID_BITS-1:0]   wr_id;
   logic                 wr_used;

   dll_seq #(
      .POOL_NODES (POOL_NODES),
      .ID_BITS    (ID_BITS),
      .NODE_BITS  (NODE_BITS),
      .LINK_BITS  (LINK_BITS)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_next (rd_next),
      .rd_prev (rd_prev),
      .rd_id   (rd_id),
      .rd_used (rd_used),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_next (wr_next),
      .wr_prev (wr_prev),
      .wr_id   (wr_id),
      .wr_used (wr_used)
   );

   dll_node_mem #(
      .POOL_NODES (POOL_NODES),
      .ID_BITS    (ID_BITS),
      .NODE_BITS  (NODE_BITS),
      .LINK_BITS  (LINK_BITS)
   ) u_node_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_next (rd_next),
      .rd_prev (rd_prev),
      .rd_id   (rd_id),
      .rd_used (rd_used),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_next (wr_next),
      .wr_prev (wr_prev),
      .wr_id   (wr_id),
      .wr_used (wr_used)
   );

endmodule
`default_nettype wire
